// File: sv/snh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package snh_pkg;
	localparam int MaxRows = 4096;
	localparam int MaxCols = 4096;
	localparam int MaxGrid = 16;
	localparam int CountBits = 32;
	localparam int RowAw = $clog2(MaxRows);
	localparam int ColAw = $clog2(MaxCols);
	localparam int GridAw = $clog2(MaxGrid);
	localparam int TileAw = 2 * GridAw;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 13;

	localparam logic [CfgIdxW-1:0] CfgSym = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgRows = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgCols = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgGrid = 2'd3;

	localparam logic [2:0] SelRow = 3'd0;
	localparam logic [2:0] SelCol = 3'd1;
	localparam logic [2:0] SelTile = 3'd2;
	localparam logic [2:0] SelRowBlk = 3'd3;
	localparam logic [2:0] SelColBlk = 3'd4;

	typedef struct packed {
		logic       req_type;
		logic [11:0] row_index;
		logic [11:0] col_index;
		logic [2:0]  table_select;
		logic [11:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [3:0]  tile_row;
		logic [3:0]  tile_col;
		logic        tiles_on;
		logic [31:0] row_total;
		logic [31:0] col_total;
		logic [31:0] tile_total;
		logic [31:0] diagonal_total;
		logic [31:0] lower_total;
		logic [31:0] upper_total;
		logic [31:0] read_value;
		logic        index_error;
	} rsp_t;
endpackage
`default_nettype wire

// File: sv/snh_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface snh_req_if;
	logic valid;
	logic ready;
	snh_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface snh_rsp_if;
	logic valid;
	logic ready;
	snh_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/sparse_nonzero_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// Sparse-matrix nonzero histogram.
// req (sink): one transaction per nonzero to add, or one read of a stored count.
// rsp (source): exactly one result transaction per request, in order.
// Config: write wr_en/wr_index/wr_data only while idle; takes effect at once.
// After reset a clearing pass zeroes every count memory (one address per
// memory per cycle); req.ready stays low meanwhile.
// An add goes through these steps after acceptance: a 13-step restoring
// divider computes the row-block split, then the column-block split, ST_BLK
// picks the block indices, the counter memories are read, bumped and written
// back, and the result is registered.
// A mirrored off-diagonal entry in symmetric mode adds a second read and
// write-back; an out-of-range add skips the memories.
// A read fetches the stored count, then registers it. One request is in
// flight at a time; the next one is accepted in the cycle after the result
// is registered, also while that result still waits. When the receiver
// stalls the result holds and the next request waits after its own
// computation, with req.ready low.
module sparse_nonzero_histogram (
	input wire logic clk,
	input wire logic arst_n,
	snh_req_if.sink req,
	snh_rsp_if.source rsp,
	input wire logic wr_en,
	input wire logic [snh_pkg::CfgIdxW-1:0] wr_index,
	input wire logic [snh_pkg::CfgDataW-1:0] wr_data
);
	localparam int RA = snh_pkg::RowAw;
	localparam int CA = snh_pkg::ColAw;
	localparam int GA = snh_pkg::GridAw;
	localparam int TA = snh_pkg::TileAw;
	localparam int CB = snh_pkg::CountBits;
	localparam int NG = snh_pkg::MaxGrid;
	localparam int NT = NG * NG;
	localparam int DW = 13;
	localparam logic [CB-1:0] CntMax = '1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DIVR, ST_DIVC, ST_BLK, ST_RD1, ST_WB1, ST_RD2, ST_WB2,
		ST_READ, ST_FIN, ST_HOLD
	} state_t;

	state_t state_q;
	logic sym_q;
	logic [12:0] rows_cfg_q, cols_cfg_q;
	logic [4:0] grid_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= 1'b0;
			rows_cfg_q <= 13'd4096;
			cols_cfg_q <= 13'd4096;
			grid_cfg_q <= 5'd16;
		end else if (wr_en) begin
			case (wr_index)
				snh_pkg::CfgSym: sym_q <= wr_data[0];
				snh_pkg::CfgRows: rows_cfg_q <= wr_data;
				snh_pkg::CfgCols: cols_cfg_q <= wr_data;
				snh_pkg::CfgGrid: grid_cfg_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	logic [12:0] rows, cols;
	logic [4:0] g;
	logic tiles;
	assign rows = (rows_cfg_q > 13'(snh_pkg::MaxRows)) ? 13'(snh_pkg::MaxRows) : rows_cfg_q;
	assign cols = (cols_cfg_q > 13'(snh_pkg::MaxCols)) ? 13'(snh_pkg::MaxCols) : cols_cfg_q;
	assign g = (grid_cfg_q > 5'(NG)) ? 5'(NG) : grid_cfg_q;
	assign tiles = (g != 5'd0) && (rows >= 13'(g)) && (cols >= 13'(g));

	// memories: all count stores are zeroed by the clearing pass
	logic [CB-1:0] row_mem [2**RA];
	logic [CB-1:0] col_mem [2**CA];
	logic [CB-1:0] tile_mem [NT];
	logic [CB-1:0] rblk_mem [NG];
	logic [CB-1:0] cblk_mem [NG];

	snh_pkg::req_t req_q;
	logic [RA:0] clr_q;
	logic [DW-1:0] rem_q, quo_q, div_d_q;
	logic [3:0] step_q;
	logic [DW-1:0] nr_q, mr_q, nc_q, mc_q;
	logic [GA-1:0] tr_q, tc_q;
	logic pass_q;
	logic [CB-1:0] diag_q, low_q, up_q;
	logic [CB-1:0] row_tot_q, col_tot_q, tile_tot_q;
	snh_pkg::rsp_t rsp_q, rsp_d;
	logic rsp_vld_q;
	logic fin_go;

	// memory read ports (registered)
	logic [RA-1:0] ra_row;
	logic [CA-1:0] ra_col;
	logic [TA-1:0] ra_tile;
	logic [GA-1:0] ra_rb, ra_cb;
	logic [CB-1:0] rd_row_s1, rd_col_s1, rd_tile_s1, rd_rb_s1, rd_cb_s1;
	logic [RA-1:0] wa_row;
	logic [CA-1:0] wa_col;
	logic [TA-1:0] wa_tile;
	logic [GA-1:0] wa_rb, wa_cb;
	logic row_ok, col_ok;

	// pass 1: (r,c); pass 2: mirrored (c,r)
	logic [11:0] pr, pc;
	logic [GA-1:0] ptr, ptc;
	assign pr = pass_q ? req_q.col_index : req_q.row_index;
	assign pc = pass_q ? req_q.row_index : req_q.col_index;
	assign ptr = pass_q ? tc_q : tr_q;
	assign ptc = pass_q ? tr_q : tc_q;
	assign row_ok = 13'(pr) < 13'(snh_pkg::MaxRows);
	assign col_ok = 13'(pc) < 13'(snh_pkg::MaxCols);

	logic [TA+GA:0] tile_prod;
	assign tile_prod = (TA+GA+1)'(ptr) * (TA+GA+1)'(g) + (TA+GA+1)'(ptc);

	// a read request keeps its entry address until the next request is accepted
	always_comb begin
		ra_row = pr[RA-1:0];
		ra_col = pc[CA-1:0];
		ra_tile = tile_prod[TA-1:0];
		ra_rb = ptr;
		ra_cb = ptc;
		if (req_q.req_type) begin
			ra_row = req_q.entry_index[RA-1:0];
			ra_col = req_q.entry_index[CA-1:0];
			ra_tile = req_q.entry_index[TA-1:0];
			ra_rb = req_q.entry_index[GA-1:0];
			ra_cb = req_q.entry_index[GA-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rd_row_s1 <= row_mem[ra_row];
		rd_col_s1 <= col_mem[ra_col];
		rd_tile_s1 <= tile_mem[ra_tile];
		rd_rb_s1 <= rblk_mem[ra_rb];
		rd_cb_s1 <= cblk_mem[ra_cb];
	end

	function automatic logic [CB-1:0] bump(input logic [CB-1:0] v);
		return (v == CntMax) ? v : v + CB'(1);
	endfunction

	logic [CB-1:0] tile_cur, rb_cur, cb_cur, row_new, col_new, tile_new;
	assign tile_cur = rd_tile_s1;
	assign rb_cur = rd_rb_s1;
	assign cb_cur = rd_cb_s1;
	assign row_new = bump(rd_row_s1);
	assign col_new = bump(rd_col_s1);
	assign tile_new = bump(tile_cur);

	logic wb, clr, do_row_wb, do_col_wb, do_tile_wb;
	assign wb = (state_q == ST_WB1) || (state_q == ST_WB2);
	assign clr = state_q == ST_CLEAR;
	assign do_row_wb = clr || (wb && row_ok);
	assign do_col_wb = clr || (wb && col_ok);
	assign do_tile_wb = clr || (wb && tiles);
	assign wa_row = clr ? clr_q[RA-1:0] : pr[RA-1:0];
	assign wa_col = clr ? clr_q[CA-1:0] : pc[CA-1:0];
	assign wa_tile = clr ? clr_q[TA-1:0] : tile_prod[TA-1:0];
	assign wa_rb = clr ? clr_q[GA-1:0] : ptr;
	assign wa_cb = clr ? clr_q[GA-1:0] : ptc;

	always_ff @(posedge clk) begin
		if (do_row_wb)
			row_mem[wa_row] <= clr ? '0 : row_new;
		if (do_col_wb)
			col_mem[wa_col] <= clr ? '0 : col_new;
		if (do_tile_wb) begin
			tile_mem[wa_tile] <= clr ? '0 : tile_new;
			rblk_mem[wa_rb] <= clr ? '0 : bump(rb_cur);
			cblk_mem[wa_cb] <= clr ? '0 : bump(cb_cur);
		end
	end

	// restoring divider: dim / g, one quotient bit per cycle
	logic [DW:0] rem_sh;
	logic [DW-1:0] rem_nx;
	logic qbit;
	assign rem_sh = {rem_q, div_d_q[DW-1]};
	assign qbit = rem_sh >= (DW+1)'(g);
	assign rem_nx = qbit ? DW'(rem_sh - (DW+1)'(g)) : rem_sh[DW-1:0];

	// block index from n, m (x / (n+1) or / n is bounded by grid: find by table)
	function automatic logic [GA-1:0] blk(input logic [11:0] x, input logic [DW-1:0] n,
		input logic [DW-1:0] m, input logic [4:0] gg);
		logic [GA-1:0] b;
		logic [DW+GA:0] lim;
		b = '0;
		for (int k = 1; k < NG; k++) begin
			lim = (k <= int'(m)) ? (DW+GA+1)'(k) * (DW+GA+1)'(n + DW'(1))
				: (DW+GA+1)'(m) + (DW+GA+1)'(k) * (DW+GA+1)'(n);
			if (k < int'(gg) && (DW+GA+1)'(x) >= lim)
				b = GA'(k);
		end
		return b;
	endfunction

	logic acc;
	assign req.ready = (state_q == ST_IDLE) || (state_q == ST_HOLD);
	assign acc = req.valid && req.ready;
	logic add_ok;
	assign add_ok = (13'(req_q.row_index) < rows) && (13'(req_q.col_index) < cols);
	logic offd;
	assign offd = req_q.row_index != req_q.col_index;

	logic [12:0] ebound;
	logic rd_err;
	always_comb begin
		case (req_q.table_select)
			snh_pkg::SelRow: ebound = rows;
			snh_pkg::SelCol: ebound = cols;
			snh_pkg::SelTile: ebound = 13'(g) * 13'(g);
			snh_pkg::SelRowBlk: ebound = 13'(g);
			snh_pkg::SelColBlk: ebound = 13'(g);
			default: ebound = '0;
		endcase
		rd_err = 13'(req_q.entry_index) >= ebound;
	end

	logic [CB-1:0] rd_val;
	always_comb begin
		case (req_q.table_select)
			snh_pkg::SelRow: rd_val = rd_row_s1;
			snh_pkg::SelCol: rd_val = rd_col_s1;
			snh_pkg::SelTile: rd_val = tile_cur;
			snh_pkg::SelRowBlk: rd_val = rb_cur;
			snh_pkg::SelColBlk: rd_val = cb_cur;
			default: rd_val = '0;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.tiles_on = tiles;
		rsp_d.diagonal_total = diag_q;
		rsp_d.lower_total = low_q;
		rsp_d.upper_total = up_q;
		if (req_q.req_type) begin
			rsp_d.read_value = rd_err ? '0 : rd_val;
			rsp_d.index_error = rd_err;
		end else if (!add_ok) begin
			rsp_d.index_error = 1'b1;
		end else begin
			rsp_d.tile_row = 4'(tr_q);
			rsp_d.tile_col = 4'(tc_q);
			rsp_d.row_total = row_tot_q;
			rsp_d.col_total = col_tot_q;
			rsp_d.tile_total = tile_tot_q;
		end
	end

	assign fin_go = (state_q == ST_FIN) && (!rsp_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_vld_q <= 1'b0;
		else if (fin_go)
			rsp_vld_q <= 1'b1;
		else if (rsp.ready)
			rsp_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			pass_q <= 1'b0;
			step_q <= '0;
			diag_q <= '0;
			low_q <= '0;
			up_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + (RA+1)'(1);
					if (clr_q == (RA+1)'(2**RA - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE, ST_HOLD: begin
					if (acc) begin
						req_q <= req.data;
						pass_q <= 1'b0;
						if (req.data.req_type) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DIVR;
							rem_q <= '0;
							div_d_q <= rows;
							step_q <= '0;
						end
					end else if (state_q == ST_HOLD && !rsp_vld_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIVR, ST_DIVC: begin
					quo_q <= {quo_q[DW-2:0], qbit};
					if (step_q == 4'(DW - 1)) begin
						step_q <= '0;
						rem_q <= '0;
						if (state_q == ST_DIVR) begin
							nr_q <= {quo_q[DW-2:0], qbit};
							mr_q <= rem_nx;
							div_d_q <= cols;
							state_q <= ST_DIVC;
						end else begin
							nc_q <= {quo_q[DW-2:0], qbit};
							mc_q <= rem_nx;
							state_q <= ST_BLK;
						end
					end else begin
						rem_q <= rem_nx;
						div_d_q <= {div_d_q[DW-2:0], 1'b0};
						step_q <= step_q + 4'd1;
					end
				end
				ST_BLK: begin
					tr_q <= tiles ? blk(req_q.row_index, nr_q, mr_q, g) : '0;
					tc_q <= tiles ? blk(req_q.col_index, nc_q, mc_q, g) : '0;
					state_q <= add_ok ? ST_RD1 : ST_FIN;
				end
				ST_RD1: state_q <= ST_WB1;
				ST_WB1: begin
					row_tot_q <= row_new;
					col_tot_q <= col_new;
					tile_tot_q <= tiles ? tile_new : '0;
					if (!offd) begin
						diag_q <= bump(diag_q);
						state_q <= ST_FIN;
					end else if (sym_q) begin
						low_q <= bump(low_q);
						up_q <= bump(up_q);
						pass_q <= 1'b1;
						state_q <= ST_RD2;
					end else begin
						if (req_q.row_index > req_q.col_index)
							low_q <= bump(low_q);
						else
							up_q <= bump(up_q);
						state_q <= ST_FIN;
					end
				end
				ST_RD2: state_q <= ST_WB2;
				ST_WB2: begin
					// mirrored entry in the same tile bumps it a second time
					if (tiles && tr_q == tc_q)
						tile_tot_q <= tile_new;
					state_q <= ST_FIN;
				end
				ST_READ: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_HOLD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && !rsp.ready |=> rsp_vld_q) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready) else $error("accept during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready) else $error("second request accepted");
endmodule
`default_nettype wire
